// ----- rtl/ddsd_pkg.sv -----
`default_nettype none
package ddsd_pkg;

	typedef logic [3:0] kind_t;

	localparam kind_t K_INT     = 4'd5;
	localparam kind_t K_STRING  = 4'd6;
	localparam kind_t K_BUFFER  = 4'd7;
	localparam kind_t K_FLOAT   = 4'd8;
	localparam kind_t K_UNUSED  = 4'd9;
	localparam kind_t K_UNDEF   = 4'd10;
	localparam kind_t K_NULL    = 4'd11;
	localparam kind_t K_TRUE    = 4'd12;
	localparam kind_t K_FALSE   = 4'd13;
	localparam kind_t K_PAYLOAD = 4'd14;
	localparam kind_t K_BAD     = 4'd15;

	// initial byte codes
	localparam logic [7:0] B_MARKER_MAX = 8'h04;
	localparam logic [7:0] B_INT4       = 8'h10;
	localparam logic [7:0] B_STR4       = 8'h11;
	localparam logic [7:0] B_STR2       = 8'h12;
	localparam logic [7:0] B_BUF4       = 8'h13;
	localparam logic [7:0] B_BUF2       = 8'h14;
	localparam logic [7:0] B_UNUSED     = 8'h15;
	localparam logic [7:0] B_UNDEF      = 8'h16;
	localparam logic [7:0] B_NULL       = 8'h17;
	localparam logic [7:0] B_TRUE       = 8'h18;
	localparam logic [7:0] B_FALSE      = 8'h19;
	localparam logic [7:0] B_FLOAT      = 8'h1A;
	localparam logic [7:0] B_OBJECT     = 8'h1B;
	localparam logic [7:0] B_POINTER    = 8'h1C;
	localparam logic [7:0] B_LIGHTFUNC  = 8'h1D;
	localparam logic [7:0] B_HEAPPTR    = 8'h1E;
	localparam logic [7:0] B_SSTR_LO    = 8'h60;
	localparam logic [7:0] B_SSTR_HI    = 8'h7F;
	localparam logic [7:0] B_SINT_LO    = 8'h80;
	localparam logic [7:0] B_SINT_HI    = 8'hBF;
	localparam logic [7:0] B_LINT_LO    = 8'hC0;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_FIELD,
		PH_PREFIX,
		PH_SIZE,
		PH_SKIP,
		PH_PAYLOAD
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] int_or_length;
		logic [63:0] float_bits;
		logic [7:0]  payload_byte;
		logic        last_payload;
	} result_t;

endpackage
`default_nettype wire

// ----- rtl/ddsd_decoder.sv -----
`default_nettype none
module ddsd_decoder
	import ddsd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] stream_byte,
	output logic            res_valid,
	output result_t         res
);

	phase_t      phase_q, phase_d;
	logic [3:0]  fbl_q, fbl_d;
	logic [63:0] acc_q, acc_d;
	logic [31:0] plen_q, plen_d;
	kind_t       pkind_q, pkind_d;

	logic [63:0] acc_shift;
	logic [3:0]  fbl_dec;
	logic [31:0] plen_dec;
	logic [31:0] len_val;
	logic        payload_last;

	assign acc_shift    = {acc_q[55:0], stream_byte};
	assign fbl_dec      = fbl_q - 4'd1;
	assign plen_dec     = plen_q - 32'd1;
	assign len_val      = acc_shift[31:0];
	assign payload_last = (plen_q <= 32'd1);

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_FIELD: begin
				if (fbl_dec == 4'd0) begin
					if ((pkind_q == K_STRING || pkind_q == K_BUFFER) && len_val != 32'd0)
						phase_d = PH_PAYLOAD;
					else
						phase_d = PH_IDLE;
				end
			end
			PH_PREFIX: begin
				if (fbl_dec == 4'd0)
					phase_d = PH_SIZE;
			end
			PH_SIZE: phase_d = (stream_byte == 8'd0) ? PH_IDLE : PH_SKIP;
			PH_SKIP: begin
				if (plen_dec == 32'd0)
					phase_d = PH_IDLE;
			end
			PH_PAYLOAD: begin
				if (payload_last)
					phase_d = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
				case (stream_byte)
					B_INT4, B_STR4, B_STR2, B_BUF4, B_BUF2, B_FLOAT: phase_d = PH_FIELD;
					B_OBJECT, B_LIGHTFUNC: phase_d = PH_PREFIX;
					B_POINTER, B_HEAPPTR: phase_d = PH_SIZE;
					default: begin
						if (stream_byte >= B_SSTR_LO && stream_byte <= B_SSTR_HI
							&& stream_byte[4:0] != 5'd0)
							phase_d = PH_PAYLOAD;
						else if (stream_byte >= B_LINT_LO)
							phase_d = PH_FIELD;
					end
				endcase
			end
		endcase
	end

	// field, length and count registers
	always_comb begin
		fbl_d   = fbl_q;
		acc_d   = acc_q;
		plen_d  = plen_q;
		pkind_d = pkind_q;
		case (phase_q)
			PH_FIELD: begin
				acc_d = acc_shift;
				fbl_d = fbl_dec;
				if (fbl_dec == 4'd0 && (pkind_q == K_STRING || pkind_q == K_BUFFER))
					plen_d = len_val;
			end
			PH_PREFIX: fbl_d = fbl_dec;
			PH_SIZE: plen_d = {24'd0, stream_byte};
			PH_SKIP: plen_d = plen_dec;
			PH_PAYLOAD: plen_d = payload_last ? 32'd0 : plen_dec;
			default: begin
				case (stream_byte)
					B_INT4: begin
						pkind_d = K_INT; fbl_d = 4'd4; acc_d = 64'd0;
					end
					B_STR4: begin
						pkind_d = K_STRING; fbl_d = 4'd4; acc_d = 64'd0;
					end
					B_STR2: begin
						pkind_d = K_STRING; fbl_d = 4'd2; acc_d = 64'd0;
					end
					B_BUF4: begin
						pkind_d = K_BUFFER; fbl_d = 4'd4; acc_d = 64'd0;
					end
					B_BUF2: begin
						pkind_d = K_BUFFER; fbl_d = 4'd2; acc_d = 64'd0;
					end
					B_FLOAT: begin
						pkind_d = K_FLOAT; fbl_d = 4'd8; acc_d = 64'd0;
					end
					B_OBJECT: fbl_d = 4'd1;
					B_LIGHTFUNC: fbl_d = 4'd2;
					default: begin
						if (stream_byte >= B_SSTR_LO && stream_byte <= B_SSTR_HI)
							plen_d = {27'd0, stream_byte[4:0]};
						else if (stream_byte >= B_LINT_LO) begin
							pkind_d = K_INT;
							fbl_d   = 4'd1;
							acc_d   = {58'd0, stream_byte[5:0]};
						end
					end
				endcase
			end
		endcase
	end

	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		case (phase_q)
			PH_FIELD: begin
				if (fbl_dec == 4'd0) begin
					res_valid = 1'b1;
					if (pkind_q == K_FLOAT) begin
						res.kind       = K_FLOAT;
						res.float_bits = acc_shift;
					end else if (pkind_q == K_STRING || pkind_q == K_BUFFER) begin
						res.kind          = pkind_q;
						res.int_or_length = len_val;
					end else begin
						res.kind          = K_INT;
						res.int_or_length = len_val;
					end
				end
			end
			PH_PREFIX: res_valid = 1'b0;
			PH_SIZE: begin
				if (stream_byte == 8'd0) begin
					res_valid = 1'b1;
					res.kind  = K_UNUSED;
				end
			end
			PH_SKIP: begin
				if (plen_dec == 32'd0) begin
					res_valid = 1'b1;
					res.kind  = K_UNUSED;
				end
			end
			PH_PAYLOAD: begin
				res_valid        = 1'b1;
				res.kind         = K_PAYLOAD;
				res.payload_byte = stream_byte;
				res.last_payload = payload_last;
			end
			default: begin
				res_valid = 1'b1;
				case (stream_byte)
					B_INT4, B_STR4, B_STR2, B_BUF4, B_BUF2, B_FLOAT,
					B_OBJECT, B_LIGHTFUNC, B_POINTER, B_HEAPPTR: res_valid = 1'b0;
					B_UNUSED: res.kind = K_UNUSED;
					B_UNDEF:  res.kind = K_UNDEF;
					B_NULL:   res.kind = K_NULL;
					B_TRUE:   res.kind = K_TRUE;
					B_FALSE:  res.kind = K_FALSE;
					default: begin
						if (stream_byte <= B_MARKER_MAX)
							res.kind = stream_byte[3:0];
						else if (stream_byte >= B_SSTR_LO && stream_byte <= B_SSTR_HI) begin
							res.kind          = K_STRING;
							res.int_or_length = {27'd0, stream_byte[4:0]};
						end else if (stream_byte >= B_SINT_LO && stream_byte <= B_SINT_HI) begin
							res.kind          = K_INT;
							res.int_or_length = {26'd0, stream_byte[5:0]};
						end else if (stream_byte >= B_LINT_LO)
							res_valid = 1'b0;
						else
							res.kind = K_BAD;
					end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			fbl_q   <= '0;
			acc_q   <= '0;
			plen_q  <= '0;
			pkind_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			fbl_q   <= fbl_d;
			acc_q   <= acc_d;
			plen_q  <= plen_d;
			pkind_q <= pkind_d;
		end
	end

`ifndef SYNTHESIS
	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> plen_q != 32'd0)
		else $error("payload phase with zero bytes left");
	a_skip_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> plen_q != 32'd0)
		else $error("skip phase with zero bytes left");
	a_field_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FIELD || phase_q == PH_PREFIX) |-> fbl_q != 4'd0)
		else $error("field phase with zero bytes left");
	a_payload_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind == K_PAYLOAD) |-> phase_q == PH_PAYLOAD)
		else $error("payload item outside payload phase");
`endif

endmodule
`default_nettype wire

// ----- rtl/ddsd_out_reg.sv -----
`default_nettype none
module ddsd_out_reg
	import ddsd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     load,
	input  wire result_t  res,
	input  wire logic     result_stall,
	output logic          result_valid,
	output result_t       res_q,
	output logic          busy
);

	logic valid_q;

	// upstream may move whenever the slot is empty or drains this cycle
	assign busy         = valid_q && result_stall;
	assign result_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (!result_stall)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !busy)
		else $error("result register overwritten while stalled");
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q)
		else $error("loaded item not presented");
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> valid_q && $stable(res_q))
		else $error("stalled item lost");
`endif

endmodule
`default_nettype wire

// ----- rtl/debug_dvalue_stream_decoder.sv -----
`default_nettype none
// Decodes a debug-link byte stream into tagged values, one byte per cycle.
// A byte is taken on every cycle that stream_valid is high, except while a
// finished item sits stalled in the result register (stream_stall is then
// high). Each byte yields at most one item, which appears on the result
// ports the cycle after the byte is taken: markers and constants at once,
// int/string/buffer/float descriptors on the last byte of their field, one
// payload_byte item per string or buffer byte, and an unused item after the
// last skipped byte of object, pointer, lightfunc and heap-pointer values.
// Unknown initial bytes give a bad-byte item. Sustained rate is one byte per
// clock while result_stall is low, through the single result register.
module debug_dvalue_stream_decoder
	import ddsd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        stream_valid,
	output logic             stream_stall,
	input  wire logic [7:0]  stream_byte,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [3:0]       kind,
	output logic signed [31:0] int_or_length,
	output logic [63:0]      float_bits,
	output logic [7:0]       payload_byte,
	output logic             last_payload
);

	logic    take;
	logic    dec_valid;
	result_t dec_res;
	result_t out_res;
	logic    busy;

	assign stream_stall = busy;
	assign take         = stream_valid && !busy;

	ddsd_decoder u_decoder (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.stream_byte (stream_byte),
		.res_valid   (dec_valid),
		.res         (dec_res)
	);

	ddsd_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (take && dec_valid),
		.res          (dec_res),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.res_q        (out_res),
		.busy         (busy)
	);

	assign kind          = out_res.kind;
	assign int_or_length = $signed(out_res.int_or_length);
	assign float_bits    = out_res.float_bits;
	assign payload_byte  = out_res.payload_byte;
	assign last_payload  = out_res.last_payload;

endmodule
`default_nettype wire
